/* hdl/swlap_pkg.sv */
// shared types and constants of the stopwatch with lap memory
package swlap_pkg;

    localparam int unsigned BTN_W = 4;
    localparam int unsigned MIN_W = 6;
    localparam int unsigned SEC_W = 6;
    localparam int unsigned HUN_W = 7;
    localparam int unsigned LAP_W = 20;

    // button codes, acted on only as exact values
    localparam logic [BTN_W-1:0] BTN_NONE        = 4'd0;
    localparam logic [BTN_W-1:0] BTN_SCROLL_DOWN = 4'd1;
    localparam logic [BTN_W-1:0] BTN_LAP         = 4'd2;
    localparam logic [BTN_W-1:0] BTN_PAUSE       = 4'd4;
    localparam logic [BTN_W-1:0] BTN_SCROLL_UP   = 4'd8;

    localparam logic [MIN_W-1:0] LIMIT_MIN   = 6'd60;
    localparam logic [SEC_W-1:0] SEC_PER_MIN = 6'd60;
    localparam logic [HUN_W-1:0] HUN_PER_SEC = 7'd100;

    localparam int unsigned PACK_MIN = 10000;
    localparam int unsigned PACK_SEC = 100;

    // rows of the lap window that scrolling keeps filled
    localparam int unsigned VISIBLE_ROWS = 3;
    // rows driven on the result word
    localparam int unsigned OUT_ROWS = 3;

    typedef logic [LAP_W-1:0] lap_word_t;

endpackage

/* hdl/swlap_in_if.sv */
// input channel: button word and hundredth tick
interface swlap_in_if
    import swlap_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] buttons;
    logic             tick;

    modport source (output valid, output buttons, output tick, input ready);
    modport sink   (input valid, input buttons, input tick, output ready);
endinterface

/* hdl/swlap_out_if.sv */
// result channel: time, status and lap window
interface swlap_out_if
    import swlap_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [HUN_W-1:0] hundredths;
    logic             running;
    logic [2:0]       lap_count;
    logic [2:0]       scroll_pos;
    logic [7:0]       lap_leds;
    lap_word_t        lap_row0;
    lap_word_t        lap_row1;
    lap_word_t        lap_row2;

    modport source (
        output valid, output minutes, output seconds, output hundredths,
        output running, output lap_count, output scroll_pos, output lap_leds,
        output lap_row0, output lap_row1, output lap_row2,
        input ready
    );
    modport sink (
        input valid, input minutes, input seconds, input hundredths,
        input running, input lap_count, input scroll_pos, input lap_leds,
        input lap_row0, input lap_row1, input lap_row2,
        output ready
    );
endinterface

/* hdl/swlap_ram.sv */
// generic single write port ram with registered read
module swlap_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* hdl/stopwatch_with_lap_memory.sv */
// top level of the run/pause stopwatch with lap memory
//
// One word in, one word out: every accepted word (button word plus hundredth
// tick) updates the watch and yields one result word holding the time after
// that update, the run flag, the lap count, the window position, a one-hot lap
// led word and three lap rows. A word is accepted every cycle as long as the
// result side takes its words; the result appears in the cycle after
// acceptance and is held in the output register until taken, and the input
// side is ready whenever that register is empty or being emptied. Buttons act
// once per press on the exact code (pause toggles run and undoes one hundredth
// when stopping, lap stores the nonzero time and clears it unless full, scroll
// down and up move the window); any other nonzero code only marks the buttons
// as held until an all-released word arrives. The tick is applied after the
// buttons and only while running; the count holds at 60:00,00. Laps live in
// three copies of a small ram, one per shown row, read at the next window
// position at acceptance; a lap written in the same cycle is forwarded. Rows
// past the stored laps read as zero, so the ram needs no clearing after reset.
module stopwatch_with_lap_memory
    import swlap_pkg::*;
#(
    parameter int unsigned MAX_LAPS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    swlap_in_if.sink    sample,
    swlap_out_if.source result
);

    // count width holds 0..MAX_LAPS, row index holds window start plus rows
    localparam int unsigned CW = $clog2(MAX_LAPS + 1);
    localparam int unsigned AW = $clog2(MAX_LAPS);
    localparam int unsigned IW = $clog2(MAX_LAPS + OUT_ROWS);
    localparam int unsigned SW = CW + 3;

    // watch state, which doubles as the result payload
    logic [MIN_W-1:0] min_reg, min_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [HUN_W-1:0] hun_reg, hun_next;
    logic             run_reg, run_next;
    logic             held_reg, held_next;
    logic [CW-1:0]    laps_reg, laps_next;
    logic [CW-1:0]    ws_reg, ws_next;
    logic             out_valid_reg;

    // after the button action, before the tick
    logic [MIN_W-1:0] min_btn;
    logic [SEC_W-1:0] sec_btn;
    logic [HUN_W-1:0] hun_btn;
    logic             run_btn;

    logic             accept;
    logic             press;
    logic             lap_wr;
    lap_word_t        lap_word;
    lap_word_t        lap_word_reg;

    logic [IW-1:0]    row_idx      [OUT_ROWS];
    logic             row_blank_reg[OUT_ROWS];
    logic             row_byp_reg  [OUT_ROWS];
    lap_word_t        row_q        [OUT_ROWS];
    lap_word_t        row_val      [OUT_ROWS];

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign press        = !held_reg && (sample.buttons != BTN_NONE);

    // held follows the button word: set by any press, cleared on release
    assign held_next = (sample.buttons != BTN_NONE);

    // packed time of the lap being stored
    assign lap_word = LAP_W'(min_reg * PACK_MIN + sec_reg * PACK_SEC + hun_reg);

    // button action
    always_comb
    begin
        min_btn   = min_reg;
        sec_btn   = sec_reg;
        hun_btn   = hun_reg;
        run_btn   = run_reg;
        laps_next = laps_reg;
        ws_next   = ws_reg;
        lap_wr    = 1'b0;
        if (press)
        begin
            case (sample.buttons)
                BTN_PAUSE:
                begin
                    run_btn = !run_reg;
                    // stopping gives back one hundredth, never below zero
                    if (run_reg)
                    begin
                        if (hun_reg != '0)
                        begin
                            hun_btn = hun_reg - 1'b1;
                        end
                        else if (sec_reg != '0)
                        begin
                            sec_btn = sec_reg - 1'b1;
                            hun_btn = HUN_PER_SEC - 1'b1;
                        end
                        else if (min_reg != '0)
                        begin
                            min_btn = min_reg - 1'b1;
                            sec_btn = SEC_PER_MIN - 1'b1;
                            hun_btn = HUN_PER_SEC - 1'b1;
                        end
                    end
                end
                BTN_LAP:
                begin
                    if (((min_reg != '0) || (sec_reg != '0) || (hun_reg != '0))
                        && (laps_reg < CW'(MAX_LAPS)))
                    begin
                        lap_wr    = 1'b1;
                        laps_next = laps_reg + 1'b1;
                        min_btn   = '0;
                        sec_btn   = '0;
                        hun_btn   = '0;
                    end
                end
                BTN_SCROLL_DOWN:
                begin
                    if ((SW'(ws_reg) + SW'(VISIBLE_ROWS)) < SW'(laps_reg))
                    begin
                        ws_next = ws_reg + 1'b1;
                    end
                end
                BTN_SCROLL_UP:
                begin
                    if (ws_reg != '0)
                    begin
                        ws_next = ws_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // hundredth tick, with carry and the hold at the limit
    always_comb
    begin
        min_next = min_btn;
        sec_next = sec_btn;
        hun_next = hun_btn;
        run_next = run_btn;
        if (sample.tick && run_btn)
        begin
            if (min_btn >= LIMIT_MIN)
            begin
                min_next = LIMIT_MIN;
                sec_next = '0;
                hun_next = '0;
            end
            else
            begin
                hun_next = hun_btn + 1'b1;
                if (hun_next >= HUN_PER_SEC)
                begin
                    hun_next = '0;
                    sec_next = sec_btn + 1'b1;
                end
                if (sec_next >= SEC_PER_MIN)
                begin
                    sec_next = '0;
                    min_next = min_btn + 1'b1;
                end
                if (min_next >= LIMIT_MIN)
                begin
                    min_next = LIMIT_MIN;
                    sec_next = '0;
                    hun_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            sec_reg       <= '0;
            hun_reg       <= '0;
            run_reg       <= 1'b0;
            held_reg      <= 1'b0;
            laps_reg      <= '0;
            ws_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                min_reg  <= min_next;
                sec_reg  <= sec_next;
                hun_reg  <= hun_next;
                run_reg  <= run_next;
                held_reg <= held_next;
                laps_reg <= laps_next;
                ws_reg   <= ws_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && lap_wr)
        begin
            lap_word_reg <= lap_word;
        end
    end

    // one ram copy per shown row, each read at its row of the next window
    for (genvar k = 0; k < OUT_ROWS; k++)
    begin : g_row
        assign row_idx[k] = IW'(ws_next) + IW'(k);

        swlap_ram #(
            .WIDTH (LAP_W),
            .DEPTH (MAX_LAPS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (accept && lap_wr),
            .wr_addr (laps_reg[AW-1:0]),
            .wr_data (lap_word),
            .rd_en   (accept),
            .rd_addr (row_idx[k][AW-1:0]),
            .rd_data (row_q[k])
        );

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                row_blank_reg[k] <= (row_idx[k] >= IW'(laps_next));
                // lap written this cycle is not yet visible at the ram output
                row_byp_reg[k]   <= lap_wr && (row_idx[k] == IW'(laps_reg));
            end
        end

        assign row_val[k] = row_blank_reg[k] ? '0 :
                            (row_byp_reg[k] ? lap_word_reg : row_q[k]);
    end

    assign result.valid      = out_valid_reg;
    assign result.minutes    = min_reg;
    assign result.seconds    = sec_reg;
    assign result.hundredths = hun_reg;
    assign result.running    = run_reg;
    assign result.lap_count  = 3'(laps_reg);
    assign result.scroll_pos = 3'(ws_reg);
    assign result.lap_leds   = ((laps_reg != '0) && (SW'(laps_reg) < SW'(8)))
                             ? (8'd1 << laps_reg[2:0]) : 8'd0;
    assign result.lap_row0   = row_val[0];
    assign result.lap_row1   = row_val[1];
    assign result.lap_row2   = row_val[2];

    // a stored lap restarts the time (a tick in the same word may add one
    // hundredth) and bumps the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && lap_wr |=> (laps_reg == $past(laps_reg) + 1'b1)
            && (min_reg == '0) && (sec_reg == '0) && (hun_reg <= HUN_W'(1)))
        else $error("lap store did not clear time or bump count");

    // the window never starts past the last full view of stored laps
    assert property (@(posedge clk) disable iff (!rst_n)
        (ws_reg != '0) |-> ((SW'(ws_reg) + SW'(VISIBLE_ROWS)) <= SW'(laps_reg)))
        else $error("lap window out of range");

    // without an accepted word the watch state does not move
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(min_reg) && $stable(sec_reg) && $stable(hun_reg)
            && $stable(laps_reg) && $stable(ws_reg) && $stable(run_reg))
        else $error("state changed without an accepted word");

endmodule
